### sv/tcp_option_value_extract_macros.svh
// Assertion macros shared by the option value extractor RTL.
`ifndef TCP_OPTION_VALUE_EXTRACT_MACROS_SVH
`define TCP_OPTION_VALUE_EXTRACT_MACROS_SVH

`ifndef SYNTHESIS

// Condition must hold at every clock edge outside reset.
`define TOVE_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("tove: invariant violated");

// Antecedent in one cycle implies consequent in the next.
`define TOVE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tove: sequence check failed");

`else

`define TOVE_ASSERT_ALWAYS(label, cond)
`define TOVE_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### sv/tove_pkg.sv
// Types and constants for the TCP option value extractor.
`default_nettype none

package tove_pkg;

    localparam int VALUE_BYTES = 8;
    localparam int VALUE_W     = VALUE_BYTES * 8;
    localparam int OUT_VALUE_W = 64;
    localparam int COUNT_W     = 8;
    localparam int BYTE_W      = 8;
    localparam int OUT_DATA_W  = OUT_VALUE_W + COUNT_W;
    localparam int STATUS_W    = 2;

    localparam logic [BYTE_W-1:0] KIND_NOP      = 8'd1;
    localparam logic [BYTE_W-1:0] LEN_NO_DATA   = 8'd2;
    localparam logic [BYTE_W-1:0] HDR_BYTES     = 8'd2;
    localparam logic [BYTE_W-1:0] KIND_RESET    = 8'd2;

    typedef enum logic [1:0] {
        PH_KIND = 2'd0,
        PH_LEN  = 2'd1,
        PH_BODY = 2'd2,
        PH_DONE = 2'd3
    } phase_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_NOT_FOUND  = 2'd0,
        ST_FOUND_NONE = 2'd1,
        ST_FOUND_DATA = 2'd2
    } status_t;

endpackage

`default_nettype wire

### sv/tcp_option_value_extract.sv
// Top level of the TCP option value extractor: byte-wise option walker.
//
//  channel   dir  handshake              payload
//  s_*       in   s_tvalid / s_tready    tdata[7:0] opt_byte, tlast = last of area
//  m_*       out  m_tvalid / m_tready    tdata value/data_bytes, tuser status
//  cfg_*     in   cfg_we (no wait)       cfg_wdata = wanted_kind
//
// One option byte per cycle, save when a last byte waits as told below. From the last
// byte of an area to its result: input register, then the parse/result register.
// Bytes that are not the last of an area never wait on the output side; a last
// byte waits only while an earlier result sits unaccepted in the output register.
// rst_n clears the walker, the input and output valid flags and sets wanted_kind to 2.
`default_nettype none

`include "tcp_option_value_extract_macros.svh"

module tcp_option_value_extract (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // configuration
    input  wire logic                          cfg_we,
    input  wire logic [tove_pkg::BYTE_W-1:0]   cfg_wdata,
    // option bytes in
    input  wire logic                          s_tvalid,
    output      logic                          s_tready,
    input  wire logic [tove_pkg::BYTE_W-1:0]   s_tdata,   // [7:0] opt_byte
    input  wire logic                          s_tlast,
    // result out
    output      logic                          m_tvalid,
    input  wire logic                          m_tready,
    output      logic [tove_pkg::OUT_DATA_W-1:0] m_tdata, // [63:0] value, [71:64] data_bytes
    output      logic [tove_pkg::STATUS_W-1:0] m_tuser    // [1:0] status
);
    import tove_pkg::*;

    // configuration register
    logic [BYTE_W-1:0] wanted_kind_reg;

    // input stage
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;

    // walker state
    phase_t             phase_reg, phase_next;
    logic [COUNT_W-1:0] skip_reg, skip_next;
    logic               match_reg, match_next;
    logic [VALUE_W-1:0] acc_reg, acc_next;
    status_t            found_reg, found_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    // result values from the updated walker state
    status_t            res_status;
    logic [VALUE_W-1:0] res_acc;
    logic [COUNT_W-1:0] res_count;

    // output stage
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [STATUS_W-1:0]   out_user_reg;

    logic fire;
    logic skip_dec_zero;

    // a byte moves on unless it is a last byte and the result slot is full and not being read
    assign fire     = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    assign skip_dec_zero = (skip_reg == COUNT_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wanted_kind_reg <= KIND_RESET;
        end
        else if (cfg_we)
        begin
            wanted_kind_reg <= cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // walker next state
    always_comb
    begin
        phase_next = phase_reg;
        skip_next  = skip_reg;
        match_next = match_reg;
        acc_next   = acc_reg;
        found_next = found_reg;
        count_next = count_reg;

        case (phase_reg)
            PH_KIND:
            begin
                // kinds 0 and 1 are single bytes
                if (in_byte_reg > KIND_NOP)
                begin
                    match_next = (in_byte_reg == wanted_kind_reg);
                    phase_next = PH_LEN;
                end
            end
            PH_LEN:
            begin
                if (in_byte_reg <= KIND_NOP)
                begin
                    // bogus length walks as a one-byte option
                    match_next = 1'b0;
                    phase_next = PH_KIND;
                end
                else if (in_byte_reg == LEN_NO_DATA)
                begin
                    if (match_reg)
                    begin
                        found_next = ST_FOUND_NONE;
                        count_next = '0;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        phase_next = PH_KIND;
                    end
                end
                else
                begin
                    skip_next  = in_byte_reg - HDR_BYTES;
                    count_next = in_byte_reg - HDR_BYTES;
                    acc_next   = '0;
                    phase_next = PH_BODY;
                end
            end
            PH_BODY:
            begin
                if (match_reg)
                begin
                    acc_next = (acc_reg << BYTE_W) | VALUE_W'(in_byte_reg);
                end
                skip_next = skip_reg - COUNT_W'(1);
                if (skip_dec_zero)
                begin
                    if (match_reg)
                    begin
                        found_next = ST_FOUND_DATA;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        phase_next = PH_KIND;
                    end
                end
            end
            default:
            begin
                // found: ignore the rest of the area
            end
        endcase

        res_status = found_next;
        res_acc    = acc_next;
        res_count  = count_next;

        // end of area: start clean on the next one
        if (in_last_reg)
        begin
            phase_next = PH_KIND;
            skip_next  = '0;
            match_next = 1'b0;
            acc_next   = '0;
            found_next = ST_NOT_FOUND;
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_KIND;
            skip_reg  <= '0;
            match_reg <= 1'b0;
            acc_reg   <= '0;
            found_reg <= ST_NOT_FOUND;
            count_reg <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            skip_reg  <= skip_next;
            match_reg <= match_next;
            acc_reg   <= acc_next;
            found_reg <= found_next;
            count_reg <= count_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && in_last_reg)
        begin
            out_user_reg <= res_status;
            if (res_status == ST_FOUND_DATA)
            begin
                out_data_reg <= {res_count, OUT_VALUE_W'(res_acc)};
            end
            else
            begin
                out_data_reg <= '0;
            end
        end
    end

    // a result without data carries zero value and count
    `TOVE_ASSERT_ALWAYS(a_zero_payload, !m_tvalid || m_tuser == ST_FOUND_DATA || m_tdata == '0)
    // walking a body always has bytes left to skip
    `TOVE_ASSERT_ALWAYS(a_body_skip, phase_reg != PH_BODY || skip_reg != '0)
    // a find parks the walker until the area ends
    `TOVE_ASSERT_ALWAYS(a_found_done, found_reg == ST_NOT_FOUND || phase_reg == PH_DONE)
    // last byte clears the walker and posts a result
    `TOVE_ASSERT_NEXT(a_last_clears, fire && in_last_reg, phase_reg == PH_KIND && m_tvalid)

endmodule

`default_nettype wire
